// ----- rtl/efra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_pkg
// shared types, constants and sequencer states of the room allocator
// ----------------------------------------------------------------------------
package efra_pkg;

	localparam int EFRA_ROOMS_DEF = 16;
	localparam int EFRA_MAX_ACTIVE = 16;
	localparam int TIME_W = 40;
	localparam int COUNT_W = 16;
	localparam int ROOM_FW = 4;
	localparam int CFG_W = 5;

	typedef logic [TIME_W-1:0] time_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [ROOM_FW-1:0] room_t;
	typedef logic [CFG_W-1:0] cfg_t;

	localparam time_t TIME_MAX = {TIME_W{1'b1}};
	localparam count_t COUNT_MAX = {COUNT_W{1'b1}};
	localparam cfg_t ROOMS_RESET = 5'd16;

	// word index of the rooms_in_use register on the config port
	localparam logic REG_ROOMS_IN_USE = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_READ,
		ST_WAIT,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic clear;
		logic rd_en;
		room_t rd_room;
		logic wr_en;
		room_t wr_room;
		time_t wr_free;
		count_t wr_count;
	} tbl_req_t;

	typedef struct packed {
		time_t free;
		count_t count;
	} tbl_rsp_t;

	typedef struct packed {
		room_t most_booked_room;
		time_t finish_time;
		time_t begin_time;
		room_t assigned_room;
	} res_t;

endpackage

// ----- rtl/earliest_free_room_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_room_allocator
// assigns each job to the first free room or the one that frees earliest
// ----------------------------------------------------------------------------
// usage:
//   requests enter on s_tvalid/s_tready, one job each, start times rising.
//   s_tdata carries start_time and end_time, s_tuser the new_batch flag,
//   which empties the table and the leader before that job is placed.
//   results leave on m_tvalid/m_tready, one per request, in order.
//   rooms_in_use is to be written over the config port only while the block is idle; the block does not enforce this.
// timing:
//   a request passes from acceptance to its result through the scan, with one
//   table read per active room, a drain state for the last read, then a read,
//   an update and a write-back of the chosen room over the table's read and
//   write ports.
//   one request is in work at a time; the next can be taken in the cycle after
//   the result has moved to the output register.
// reset and stall:
//   reset empties the table (valid bits, no clearing pass), clears the
//   leader and sets rooms_in_use to 16. a stalled output holds its result
//   and the sequencer waits before writing back the next one.
// ----------------------------------------------------------------------------
module earliest_free_room_allocator
	import efra_pkg::*;
#(
	parameter int ROOMS = EFRA_ROOMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // start_time[31:0], end_time[63:32]
	input  logic        s_tuser,   // new_batch[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // assigned_room[3:0], begin_time[43:4],
	                               // finish_time[83:44], most_booked_room[87:84]
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t rooms_in_use;
	tbl_req_t tbl_req;
	tbl_rsp_t tbl_rsp;
	logic res_valid;
	res_t res;
	logic out_free;
	logic out_valid_q;
	res_t out_data_q;

	efra_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.rooms_in_use (rooms_in_use)
	);

	efra_table #(.ROOMS(ROOMS)) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (tbl_req),
		.rsp    (tbl_rsp)
	);

	efra_ctrl #(.ROOMS(ROOMS)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.start_time   (s_tdata[31:0]),
		.end_time     (s_tdata[63:32]),
		.new_batch    (s_tuser),
		.rooms_in_use (rooms_in_use),
		.tbl_req      (tbl_req),
		.tbl_rsp      (tbl_rsp),
		.out_free     (out_free),
		.res_valid    (res_valid),
		.res          (res)
	);

	// output register parts the sequencer from the receiver
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			out_data_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

endmodule

// ----- rtl/efra_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_regs
// config register file: rooms_in_use behind a two-phase write port
// ----------------------------------------------------------------------------
module efra_regs
	import efra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        rooms_in_use
);

	cfg_t rooms_q;
	logic hit;

	assign hit = (paddr[2] == REG_ROOMS_IN_USE);
	assign pready = 1'b1;
	assign rooms_in_use = rooms_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rooms_q <= ROOMS_RESET;
		end else if (psel && penable && pwrite && hit) begin
			rooms_q <= pwdata[CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(32-CFG_W){1'b0}}, rooms_q};
		end
	end

endmodule

// ----- rtl/efra_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_table
// room table memory: free time and use count per room, registered read
// ----------------------------------------------------------------------------
module efra_table
	import efra_pkg::*;
#(
	parameter int ROOMS = EFRA_ROOMS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  tbl_req_t req,
	output tbl_rsp_t rsp
);

	localparam int ADDR_W = (ROOMS > 1) ? $clog2(ROOMS) : 1;

	tbl_rsp_t mem [ROOMS];
	logic [ROOMS-1:0] valid_q;
	tbl_rsp_t rd_data_s1;
	logic rd_vld_s1;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	assign rd_addr = ADDR_W'(req.rd_room);
	assign wr_addr = ADDR_W'(req.wr_room);

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wr_addr] <= '{free: req.wr_free, count: req.wr_count};
		end
		if (req.rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// entries not written since the last clear read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rsp = rd_vld_s1 ? rd_data_s1 : '0;

endmodule

// ----- rtl/efra_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efra_ctrl
// job sequencer: scans the table, picks a room, updates it and the leader
// ----------------------------------------------------------------------------
module efra_ctrl
	import efra_pkg::*;
#(
	parameter int ROOMS = EFRA_ROOMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] start_time,
	input  logic [31:0] end_time,
	input  logic        new_batch,
	input  cfg_t        rooms_in_use,
	output tbl_req_t    tbl_req,
	input  tbl_rsp_t    tbl_rsp,
	input  logic        out_free,
	output logic        res_valid,
	output res_t        res
);

	localparam cfg_t MAX_ACT = CFG_W'((ROOMS < EFRA_MAX_ACTIVE) ? ROOMS : EFRA_MAX_ACTIVE);

	state_t state_q, state_n;

	logic [31:0] start_q;
	logic [31:0] dur_q;
	cfg_t active_q;
	cfg_t rd_idx_q;
	logic cmp_vld_s1;
	room_t cmp_idx_s1;
	logic found_q;
	room_t pick_q;
	time_t min_q;
	room_t min_idx_q;
	time_t begin_q;
	time_t finish_q;
	count_t count_q;
	room_t best_room_q;
	count_t best_count_q;

	logic accept;
	logic scan_last;
	logic fire;
	logic better;
	cfg_t active_n;
	time_t begin_w;
	logic [TIME_W:0] sum_w;

	assign accept = in_valid && in_ready;
	assign scan_last = ((rd_idx_q + 5'd1) == active_q);
	assign fire = (state_q == ST_WRITE) && out_free;
	assign better = (count_q > best_count_q) ||
		((count_q == best_count_q) && (pick_q < best_room_q));

	always_comb begin
		active_n = rooms_in_use;
		if (active_n == '0) begin
			active_n = 5'd1;
		end
		if (active_n > MAX_ACT) begin
			active_n = MAX_ACT;
		end
	end

	assign begin_w = found_q ? {{(TIME_W-32){1'b0}}, start_q} : tbl_rsp.free;
	assign sum_w = {1'b0, begin_w} + (TIME_W+1)'(dur_q);

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_n = ST_SCAN;
			ST_SCAN:  if (scan_last) state_n = ST_DRAIN;
			ST_DRAIN: state_n = ST_READ;
			ST_READ:  state_n = ST_WAIT;
			ST_WAIT:  state_n = ST_WRITE;
			ST_WRITE: if (out_free) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = (state_q == ST_IDLE);
		tbl_req = '0;
		tbl_req.clear = accept && new_batch;
		tbl_req.rd_en = (state_q == ST_SCAN) || (state_q == ST_READ);
		tbl_req.rd_room = (state_q == ST_READ) ? (found_q ? pick_q : min_idx_q)
			: rd_idx_q[ROOM_FW-1:0];
		tbl_req.wr_en = fire;
		tbl_req.wr_room = pick_q;
		tbl_req.wr_free = finish_q;
		tbl_req.wr_count = count_q;
		res_valid = fire;
		res.assigned_room = pick_q;
		res.begin_time = begin_q;
		res.finish_time = finish_q;
		res.most_booked_room = better ? pick_q : best_room_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmp_vld_s1 <= 1'b0;
			best_room_q <= '0;
			best_count_q <= '0;
		end else begin
			state_q <= state_n;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (accept && new_batch) begin
				best_room_q <= '0;
				best_count_q <= '0;
			end else if (fire && better) begin
				best_room_q <= pick_q;
				best_count_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			start_q <= start_time;
			dur_q <= (end_time > start_time) ? (end_time - start_time) : '0;
			active_q <= active_n;
			rd_idx_q <= '0;
			found_q <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			rd_idx_q <= rd_idx_q + 5'd1;
			cmp_idx_s1 <= rd_idx_q[ROOM_FW-1:0];
		end
		// first free room wins, else the earliest freeing one, lowest index on ties
		if (cmp_vld_s1) begin
			if (!found_q && (tbl_rsp.free <= {{(TIME_W-32){1'b0}}, start_q})) begin
				found_q <= 1'b1;
				pick_q <= cmp_idx_s1;
			end
			if ((cmp_idx_s1 == '0) || (tbl_rsp.free < min_q)) begin
				min_q <= tbl_rsp.free;
				min_idx_q <= cmp_idx_s1;
			end
		end
		if (state_q == ST_READ) begin
			pick_q <= found_q ? pick_q : min_idx_q;
		end
		if (state_q == ST_WAIT) begin
			begin_q <= begin_w;
			finish_q <= sum_w[TIME_W] ? TIME_MAX : sum_w[TIME_W-1:0];
			count_q <= (tbl_rsp.count == COUNT_MAX) ? COUNT_MAX : tbl_rsp.count + 16'd1;
		end
	end

	a_room_active: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ({1'b0, pick_q} < active_q))
		else $error("assigned room outside the active range");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> ({1'b0, cmp_idx_s1} < active_q))
		else $error("scan compared an inactive room");

	a_free_begin: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && found_q) |-> (res.begin_time == {{(TIME_W-32){1'b0}}, start_q}))
		else $error("free room did not begin at the request start");

	a_finish_order: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.finish_time >= res.begin_time))
		else $error("finish before begin");

	a_one_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_WAIT) && !cmp_vld_s1)
		else $error("pick read overlapped the scan");

endmodule

// ----- test/earliest_free_room_allocator_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// earliest_free_room_allocator_tb
// self-checking bench for the room allocator: jobs go in on the request
// stream with random gaps, results are taken with random back-pressure and
// compared field by field against a local model of the room table.
// rooms_in_use is rewritten between phases over the config port.
// ----------------------------------------------------------------------------
module earliest_free_room_allocator_tb;
	import efra_pkg::*;

	localparam int ROOMS_N = EFRA_ROOMS_DEF;
	localparam logic [2:0] ADDR_ROOMS = 3'(4 * REG_ROOMS_IN_USE);
	localparam logic [2:0] ADDR_SPARE = 3'd4;
	localparam logic [31:0] T_MAX32 = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [63:0] s_tdata = '0;   // start_time[31:0], end_time[63:32]
	logic s_tuser = 1'b0;        // new_batch[0]
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;        // assigned_room[3:0], begin_time[43:4],
	                             // finish_time[83:44], most_booked_room[87:84]
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	earliest_free_room_allocator #(.ROOMS(ROOMS_N)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// local copy of the room table
	time_t room_free [ROOMS_N];
	count_t room_uses [ROOMS_N];
	room_t top_room;
	count_t top_count;
	cfg_t rooms_cfg;

	res_t job_results [$];
	int mismatches = 0;
	bit steady = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#60_000_000;
		$display("earliest_free_room_allocator_tb failed");
		$finish;
	end

	function automatic void clear_rooms();
		for (int r = 0; r < ROOMS_N; r++) begin
			room_free[r] = '0;
			room_uses[r] = '0;
		end
		top_room = '0;
		top_count = '0;
	endfunction

	function automatic int active_rooms();
		int n;
		n = (rooms_cfg == 0) ? 1 : int'(rooms_cfg);
		if (n > ROOMS_N) n = ROOMS_N;
		if (n > EFRA_MAX_ACTIVE) n = EFRA_MAX_ACTIVE;
		return n;
	endfunction

	function automatic res_t place_job(logic [31:0] st, logic [31:0] en, logic nb);
		res_t r;
		int active;
		int pick;
		bit found;
		logic [31:0] dur;
		logic [TIME_W:0] sum;
		time_t begin_t;
		time_t finish_t;
		if (nb) clear_rooms();
		active = active_rooms();
		dur = (en > st) ? en - st : '0;
		found = 1'b0;
		pick = 0;
		for (int i = 0; i < active; i++) begin
			if (!found && room_free[i] <= time_t'(st)) begin
				pick = i;
				found = 1'b1;
			end
		end
		if (!found) begin
			// every active room busy: earliest to free, lowest index on ties
			for (int i = 1; i < active; i++)
				if (room_free[i] < room_free[pick]) pick = i;
			begin_t = room_free[pick];
		end else begin
			begin_t = time_t'(st);
		end
		sum = {1'b0, begin_t} + (TIME_W + 1)'(dur);
		finish_t = (sum > {1'b0, TIME_MAX}) ? TIME_MAX : sum[TIME_W-1:0];
		room_free[pick] = finish_t;
		if (room_uses[pick] != COUNT_MAX) room_uses[pick]++;
		if (room_uses[pick] > top_count ||
			(room_uses[pick] == top_count && room_t'(pick) < top_room)) begin
			top_count = room_uses[pick];
			top_room = room_t'(pick);
		end
		r.assigned_room = room_t'(pick);
		r.begin_time = begin_t;
		r.finish_time = finish_t;
		r.most_booked_room = top_room;
		return r;
	endfunction

	function automatic void check_field(string name, logic [39:0] want, logic [39:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : result_check
		res_t got;
		res_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(0, 99) >= 14);
			if (m_tvalid && m_tready) begin
				got = res_t'(m_tdata);
				if (job_results.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h",
						$time, m_tdata);
					mismatches++;
				end else begin
					want = job_results.pop_front();
					check_field("assigned_room", 40'(want.assigned_room),
						40'(got.assigned_room));
					check_field("begin_time", want.begin_time, got.begin_time);
					check_field("finish_time", want.finish_time, got.finish_time);
					check_field("most_booked_room", 40'(want.most_booked_room),
						40'(got.most_booked_room));
				end
			end
		end
	end

	// returns at the edge where the request was taken, tvalid still high
	task automatic send_job(input logic [31:0] st, input logic [31:0] en, input logic nb);
		if (!steady && $urandom_range(0, 99) < 14) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {en, st};
		s_tuser <= nb;
		do @(posedge clk); while (!s_tready);
		job_results.push_back(place_job(st, en, nb));
	endtask

	task automatic wait_all_results(input int settle);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (job_results.size() != 0);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_ROOMS) rooms_cfg = data[CFG_W-1:0];
		@(posedge clk);
	endtask

	task automatic apb_check_rooms();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_ROOMS;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== 32'(rooms_cfg)) begin
			$display("%0t: rooms_in_use readback mismatch, expected %h, actual %h",
				$time, 32'(rooms_cfg), prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_rooms(input logic [31:0] value);
		wait_all_results(4);
		apb_write(ADDR_ROOMS, value);
		apb_check_rooms();
	endtask

	task automatic test_reset_value();
		apb_check_rooms();
	endtask

	task automatic test_directed();
		send_job(0, 0, 1'b0);                    // zero length at time zero
		send_job(1, 0, 1'b0);                    // end before start
		send_job(2, 100, 1'b0);
		send_job(3, 50, 1'b0);
		send_job(4, 60, 1'b0);
		send_job(5, 5, 1'b0);
		send_job(32'h8000_0000, T_MAX32, 1'b0);
		send_job(32'h8000_0001, 32'h8000_0002, 1'b0);
		send_job(3, 4, 1'b0);                    // start goes backwards
		send_job(T_MAX32, T_MAX32, 1'b0);
		send_job(T_MAX32, 0, 1'b0);
		send_job(0, T_MAX32, 1'b1);
		send_job(1, T_MAX32, 1'b0);
		send_job(32'hFFFF_FFFE, T_MAX32, 1'b0);
		send_job(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
		send_job(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
	endtask

	task automatic test_room_limits();
		set_rooms(2);
		send_job(10, 20, 1'b1);
		send_job(11, 30, 1'b0);
		send_job(12, 15, 1'b0);                  // both busy, waits for room 0
		send_job(0, 10, 1'b1);
		send_job(1, 10, 1'b0);
		send_job(2, 5, 1'b0);                    // both free at the same time
		set_rooms(0);                            // behaves as one room
		send_job(5, 9, 1'b1);
		send_job(6, 8, 1'b0);
		send_job(7, 7, 1'b0);
		set_rooms(31);                           // clipped to sixteen
		send_job(100, 200, 1'b1);
		send_job(101, 200, 1'b0);
		send_job(102, 103, 1'b0);
		set_rooms(8);
		for (int i = 0; i < 8; i++)
			send_job(32'(i), 32'(1000 - 10 * i), i == 0);
		for (int i = 8; i < 11; i++)
			send_job(32'(i), 32'(i + 12), 1'b0);
		// shrink mid-batch: upper rooms keep their entries and counts
		set_rooms(3);
		for (int i = 11; i < 16; i++)
			send_job(32'(i), 32'(i + 40), 1'b0);
		wait_all_results(4);
		apb_write(ADDR_SPARE, 32'd5);            // no such register
		apb_check_rooms();
		send_job(16, 17, 1'b0);
		send_job(2000, 2001, 1'b0);
		set_rooms(1);
		send_job(2001, 2100, 1'b0);
		send_job(2002, 2003, 1'b0);
		set_rooms(16);
	endtask

	// one room: free time runs into its ceiling after a few hundred jobs
	task automatic test_saturation();
		steady = 1'b1;
		set_rooms(1);
		for (int i = 0; i < 264; i++)
			send_job(32'(i), T_MAX32, i == 0);
		wait_all_results(4);
		apb_write(ADDR_ROOMS, 2);
		send_job(70000, 70010, 1'b0);
		send_job(70001, 70020, 1'b0);
		steady = 1'b0;
	endtask

	task automatic test_random();
		int unsigned roll;
		int unsigned batch_left;
		int unsigned k;
		logic [31:0] room_sel;
		longint unsigned cur;
		longint unsigned gap_max;
		longint unsigned dur_max;
		longint unsigned en64;
		logic nb;
		for (int phase = 0; phase < 12; phase++) begin
			steady = (phase == 3);
			case (phase)
				0: room_sel = 1;
				1: room_sel = 16;
				2: room_sel = 0;
				3: room_sel = 31;
				default: room_sel = $urandom_range(0, 31);
			endcase
			set_rooms(room_sel);
			batch_left = 0;
			gap_max = 1;
			dur_max = 1;
			cur = 0;
			for (int n = 0; n < 104; n++) begin
				if (batch_left == 0 || cur + gap_max > 64'(T_MAX32)) begin
					batch_left = $urandom_range(4, 60);
					k = $urandom_range(0, 24);
					gap_max = 64'd1 << k;
					dur_max = gap_max * active_rooms() * $urandom_range(1, 3);
					if (dur_max > 64'(T_MAX32)) dur_max = 64'(T_MAX32);
					cur = $urandom_range(0, 1) ? $urandom_range(0, 255) : $urandom();
					nb = 1'b1;
				end else begin
					cur += $urandom_range(1, 32'(gap_max));
					nb = 1'b0;
				end
				batch_left--;
				en64 = cur + $urandom_range(0, 32'(dur_max));
				if (en64 > 64'(T_MAX32)) en64 = 64'(T_MAX32);
				roll = $urandom_range(0, 99);
				if (roll < 8)
					send_job($urandom(), $urandom(), $urandom_range(0, 7) == 0);
				else if (roll < 11)
					send_job(32'(cur), $urandom_range(0, 32'(cur)), nb);
				else
					send_job(32'(cur), 32'(en64), nb);
				if ($urandom_range(0, 99) < 2) wait_all_results(1);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		clear_rooms();
		rooms_cfg = ROOMS_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_value();
		test_directed();
		test_room_limits();
		test_saturation();
		test_random();
		wait_all_results(40);
		if (mismatches == 0 && job_results.size() == 0) begin
			$display("earliest_free_room_allocator_tb passed");
		end else begin
			$display("earliest_free_room_allocator_tb failed");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/efra_pkg.sv
rtl/efra_regs.sv
rtl/efra_table.sv
rtl/efra_ctrl.sv
rtl/earliest_free_room_allocator.sv
test/earliest_free_room_allocator_tb.sv
